FILE: rtl/biquad_iir_filter_macros.svh
// assertion helpers shared by the rtl
`ifndef BIQUAD_IIR_FILTER_MACROS_SVH
`define BIQUAD_IIR_FILTER_MACROS_SVH

// same-cycle implication, held off during reset
`define BQF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("biquad check failed");

// next-cycle implication, held off during reset
`define BQF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("biquad check failed");

`endif

FILE: rtl/bqf_pkg.sv
`timescale 1ns / 1ps
package bqf_pkg;

  // field and datapath widths
  localparam int SAMPLE_WIDTH    = 16;
  localparam int COEF_WIDTH      = 18;
  localparam int COEF_FRAC_BITS  = 14;
  localparam int DELAY_WIDTH     = SAMPLE_WIDTH + COEF_WIDTH + 2;
  localparam int ACC_WIDTH       = DELAY_WIDTH + 2;
  localparam int PROD_WIDTH      = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int SHIFT_WIDTH     = ACC_WIDTH - COEF_FRAC_BITS;
  localparam int NUM_COEFS       = 5;
  localparam int CFG_INDEX_WIDTH = $clog2(NUM_COEFS);

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FF_COEF_0 = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FF_COEF_1 = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FF_COEF_2 = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FB_COEF_1 = CFG_INDEX_WIDTH'(3);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FB_COEF_2 = CFG_INDEX_WIDTH'(4);

  // unity gain a0 after reset
  localparam logic signed [COEF_WIDTH-1:0] COEF_UNITY =
    COEF_WIDTH'(2 ** COEF_FRAC_BITS);

  // half an lsb of the output, for round to nearest
  localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF =
    ACC_WIDTH'(2 ** (COEF_FRAC_BITS - 1));

  // saturation bounds
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A0,
    ST_ROUND,
    ST_SAT,
    ST_FB1,
    ST_FB2,
    ST_FIN,
    ST_OUT
  } state_t;

  // control of the shared multiply-add unit
  typedef struct packed {
    logic mul_en;
    logic sub;
    logic round;
  } mac_ctrl_t;

endpackage

FILE: rtl/bqf_if.sv
`timescale 1ns / 1ps
// input sample channel
interface bqf_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// filtered sample channel
interface bqf_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]  sample_out;
  logic                                     clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

FILE: rtl/bqf_mac.sv
`timescale 1ns / 1ps
module bqf_mac (
  input  logic                                    clk,
  input  bqf_pkg::mac_ctrl_t                      ctrl,
  input  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] mul_a,
  input  logic signed [bqf_pkg::COEF_WIDTH-1:0]   mul_b,
  input  logic signed [bqf_pkg::ACC_WIDTH-1:0]    add_a,
  input  logic signed [bqf_pkg::ACC_WIDTH-1:0]    add_b,
  output logic signed [bqf_pkg::ACC_WIDTH-1:0]    prod,
  output logic signed [bqf_pkg::ACC_WIDTH-1:0]    sum
);

  logic signed [bqf_pkg::PROD_WIDTH-1:0] prod_reg;
  logic signed [bqf_pkg::ACC_WIDTH-1:0]  add_b_eff;
  logic signed [bqf_pkg::ACC_WIDTH-1:0]  round_term;

  // registered multiplier
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_reg <= mul_a * mul_b;
    end
  end

  assign prod = {{(bqf_pkg::ACC_WIDTH - bqf_pkg::PROD_WIDTH){prod_reg[bqf_pkg::PROD_WIDTH-1]}},
                 prod_reg};

  // add or subtract, with optional rounding offset
  assign add_b_eff  = ctrl.sub ? -add_b : add_b;
  assign round_term = ctrl.round ? bqf_pkg::ROUND_HALF : '0;
  assign sum        = add_a + add_b_eff + round_term;

endmodule

FILE: rtl/biquad_iir_filter.sv
`timescale 1ns / 1ps
// Second-order IIR section, transposed direct form II, fixed point.
// sample_ch carries one signed sample per beat; result_ch returns one
// filtered sample per beat with a clipped flag set when the rounded output
// had to be saturated. Coefficients (a0 a1 a2 b1 b2, 14 fraction bits) are
// written through cfg_we / cfg_index / cfg_data; any write to a valid index
// also clears both delay registers, other indexes are ignored.
// Sequence: a sample is taken in the idle state, then one shared 16x18
// multiplier and one 38-bit adder run five products and four sums over six
// sequencer steps; the result is then loaded into the output register in a
// final output step. The block returns to the idle state after the load and
// takes a new sample only there, so it does not accept the next sample until
// it is through with the last one.
// A stalled receiver holds the result register; an already loaded result
// does not stop the next sample, but the block waits in its last step until
// the output register is free.
// Reset (rst, synchronous) empties the output, restores a0 to 1.0, the other
// coefficients to zero and clears both delays.
`include "biquad_iir_filter_macros.svh"

module biquad_iir_filter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bqf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [bqf_pkg::COEF_WIDTH-1:0]        cfg_data,
  bqf_in_if.sink                                sample_ch,
  bqf_out_if.source                             result_ch
);

  bqf_pkg::state_t state, state_next;

  logic signed [bqf_pkg::COEF_WIDTH-1:0]   ff_coef_0, ff_coef_1, ff_coef_2;
  logic signed [bqf_pkg::COEF_WIDTH-1:0]   fb_coef_1, fb_coef_2;
  logic signed [bqf_pkg::DELAY_WIDTH-1:0]  delay_first, delay_second;
  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] x_reg, y_reg;
  logic                                    clip_reg;
  logic signed [bqf_pkg::ACC_WIDTH-1:0]    acc;

  logic                                    out_valid;
  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] out_sample;
  logic                                    out_clip;

  bqf_pkg::mac_ctrl_t                      mac_ctrl;
  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] mul_a;
  logic signed [bqf_pkg::COEF_WIDTH-1:0]   mul_b;
  logic signed [bqf_pkg::ACC_WIDTH-1:0]    add_a, add_b, prod, sum;

  logic                                    in_beat;
  logic                                    out_load;
  logic                                    cfg_hit;

  logic signed [bqf_pkg::SHIFT_WIDTH-1:0]  shifted;
  logic                                    sat_hi, sat_lo;
  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] y_sat;

  assign in_beat  = sample_ch.valid && sample_ch.ready;
  assign out_load = (state == bqf_pkg::ST_OUT) && (!out_valid || result_ch.ready);
  assign cfg_hit  = cfg_we && (cfg_index < bqf_pkg::CFG_INDEX_WIDTH'(bqf_pkg::NUM_COEFS));

  // shared multiply-add unit
  bqf_mac u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .add_a (add_a),
    .add_b (add_b),
    .prod  (prod),
    .sum   (sum)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bqf_pkg::ST_IDLE:   if (in_beat) state_next = bqf_pkg::ST_MUL_A0;
      bqf_pkg::ST_MUL_A0: state_next = bqf_pkg::ST_ROUND;
      bqf_pkg::ST_ROUND:  state_next = bqf_pkg::ST_SAT;
      bqf_pkg::ST_SAT:    state_next = bqf_pkg::ST_FB1;
      bqf_pkg::ST_FB1:    state_next = bqf_pkg::ST_FB2;
      bqf_pkg::ST_FB2:    state_next = bqf_pkg::ST_FIN;
      bqf_pkg::ST_FIN:    state_next = bqf_pkg::ST_OUT;
      bqf_pkg::ST_OUT:    if (out_load) state_next = bqf_pkg::ST_IDLE;
      default:            state_next = bqf_pkg::ST_IDLE;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    mac_ctrl = '0;
    mul_a    = x_reg;
    mul_b    = ff_coef_0;
    add_a    = acc;
    add_b    = prod;
    unique case (state)
      bqf_pkg::ST_MUL_A0: begin
        mac_ctrl.mul_en = 1'b1;
      end
      bqf_pkg::ST_ROUND: begin
        // acc = x*a0 + s1 + half lsb, start x*a1
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.round  = 1'b1;
        mul_b = ff_coef_1;
        add_a = {{(bqf_pkg::ACC_WIDTH - bqf_pkg::DELAY_WIDTH){delay_first[bqf_pkg::DELAY_WIDTH-1]}},
                 delay_first};
      end
      bqf_pkg::ST_SAT: begin
        // acc = x*a1 + s2, start x*a2
        mac_ctrl.mul_en = 1'b1;
        mul_b = ff_coef_2;
        add_a = {{(bqf_pkg::ACC_WIDTH - bqf_pkg::DELAY_WIDTH){delay_second[bqf_pkg::DELAY_WIDTH-1]}},
                 delay_second};
      end
      bqf_pkg::ST_FB1: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a = y_reg;
        mul_b = fb_coef_1;
      end
      bqf_pkg::ST_FB2: begin
        // s1' = acc - b1*y, start b2*y
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.sub    = 1'b1;
        mul_a = y_reg;
        mul_b = fb_coef_2;
      end
      bqf_pkg::ST_FIN: begin
        // s2' = x*a2 - b2*y
        mac_ctrl.sub = 1'b1;
        add_a = {{(bqf_pkg::ACC_WIDTH - bqf_pkg::DELAY_WIDTH){delay_second[bqf_pkg::DELAY_WIDTH-1]}},
                 delay_second};
      end
      bqf_pkg::ST_IDLE, bqf_pkg::ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // rounding shift and saturation of the accumulator
  assign shifted = acc[bqf_pkg::ACC_WIDTH-1:bqf_pkg::COEF_FRAC_BITS];
  assign sat_hi  = !shifted[bqf_pkg::SHIFT_WIDTH-1]
                   && (|shifted[bqf_pkg::SHIFT_WIDTH-2:bqf_pkg::SAMPLE_WIDTH-1]);
  assign sat_lo  = shifted[bqf_pkg::SHIFT_WIDTH-1]
                   && !(&shifted[bqf_pkg::SHIFT_WIDTH-2:bqf_pkg::SAMPLE_WIDTH-1]);
  always_comb begin
    priority if (sat_hi) begin
      y_sat = bqf_pkg::SAMPLE_MAX;
    end else if (sat_lo) begin
      y_sat = bqf_pkg::SAMPLE_MIN;
    end else begin
      y_sat = shifted[bqf_pkg::SAMPLE_WIDTH-1:0];
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bqf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // coefficients and delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      ff_coef_0    <= bqf_pkg::COEF_UNITY;
      ff_coef_1    <= '0;
      ff_coef_2    <= '0;
      fb_coef_1    <= '0;
      fb_coef_2    <= '0;
      delay_first  <= '0;
      delay_second <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        bqf_pkg::REG_FF_COEF_0: ff_coef_0 <= cfg_data;
        bqf_pkg::REG_FF_COEF_1: ff_coef_1 <= cfg_data;
        bqf_pkg::REG_FF_COEF_2: ff_coef_2 <= cfg_data;
        bqf_pkg::REG_FB_COEF_1: fb_coef_1 <= cfg_data;
        bqf_pkg::REG_FB_COEF_2: fb_coef_2 <= cfg_data;
        default: begin
        end
      endcase
      delay_first  <= '0;
      delay_second <= '0;
    end else begin
      unique case (state)
        bqf_pkg::ST_FB1: delay_second <= prod[bqf_pkg::DELAY_WIDTH-1:0];
        bqf_pkg::ST_FB2: delay_first  <= sum[bqf_pkg::DELAY_WIDTH-1:0];
        bqf_pkg::ST_FIN: delay_second <= sum[bqf_pkg::DELAY_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      x_reg <= sample_ch.sample_in;
    end
    if (state == bqf_pkg::ST_ROUND || state == bqf_pkg::ST_SAT) begin
      acc <= sum;
    end
    if (state == bqf_pkg::ST_SAT) begin
      y_reg    <= y_sat;
      clip_reg <= sat_hi || sat_lo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= y_reg;
      out_clip   <= clip_reg;
    end
  end

  assign sample_ch.ready      = (state == bqf_pkg::ST_IDLE);
  assign result_ch.valid      = out_valid;
  assign result_ch.sample_out = out_sample;
  assign result_ch.clipped    = out_clip;

  // checks
  `BQF_ASSERT_NEXT(a_accept_starts, clk, rst, in_beat, state == bqf_pkg::ST_MUL_A0)
  `BQF_ASSERT_NEXT(a_load_gives_valid, clk, rst, out_load, result_ch.valid)
  `BQF_ASSERT_NOW(a_clip_at_bound, clk, rst, result_ch.valid && result_ch.clipped,
    result_ch.sample_out == bqf_pkg::SAMPLE_MAX || result_ch.sample_out == bqf_pkg::SAMPLE_MIN)
  `BQF_ASSERT_NEXT(a_cfg_clears_delays, clk, rst, cfg_hit,
    delay_first == '0 && delay_second == '0)

endmodule
